// ===== rtl/rlgf_pkg.sv =====
// shared constants and types for the rgb linear gradient fill block
package rlgf_pkg;

	localparam int POS_W     = 6;
	localparam int COL_W     = 8;
	localparam int ACC_W     = 16;
	localparam int FRAC_SH   = 7;
	localparam int DIV_W     = COL_W + FRAC_SH;
	localparam int SPAN_W    = POS_W;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);
	localparam int NUM_CHAN  = 3;
	localparam int CHAN_W    = $clog2(NUM_CHAN);

	// operands for one signed division, given as magnitude and sign
	typedef struct packed {
		logic [DIV_W-1:0]  mag;
		logic [SPAN_W-1:0] divisor;
		logic              neg;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== rtl/rlgf_if.sv =====
// command and pixel channel interfaces
interface rlgf_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [rlgf_pkg::POS_W-1:0] start_pos;
	logic [rlgf_pkg::COL_W-1:0] start_red;
	logic [rlgf_pkg::COL_W-1:0] start_green;
	logic [rlgf_pkg::COL_W-1:0] start_blue;
	logic [rlgf_pkg::POS_W-1:0] end_pos;
	logic [rlgf_pkg::COL_W-1:0] end_red;
	logic [rlgf_pkg::COL_W-1:0] end_green;
	logic [rlgf_pkg::COL_W-1:0] end_blue;

	modport source (
		output valid, start_pos, start_red, start_green, start_blue,
		output end_pos, end_red, end_green, end_blue,
		input  ready
	);
	modport sink (
		input  valid, start_pos, start_red, start_green, start_blue,
		input  end_pos, end_red, end_green, end_blue,
		output ready
	);
endinterface

interface rlgf_pix_if;
	logic                       valid;
	logic                       ready;
	logic [rlgf_pkg::POS_W-1:0] pixel_index;
	logic [rlgf_pkg::COL_W-1:0] pixel_red;
	logic [rlgf_pkg::COL_W-1:0] pixel_green;
	logic [rlgf_pkg::COL_W-1:0] pixel_blue;
	logic                       run_last;

	modport source (
		output valid, pixel_index, pixel_red, pixel_green, pixel_blue, run_last,
		input  ready
	);
	modport sink (
		input  valid, pixel_index, pixel_red, pixel_green, pixel_blue, run_last,
		output ready
	);
endinterface

// ===== rtl/rgb_linear_gradient_fill.sv =====
// rgb linear gradient fill: one command in, one pixel out per position of the run
// sequence: take the command, then the per-channel steps in turn for the three channels
// on the shared 15-step divider, then the pixels of the run,
// one pixel per cycle while the sink is ready
// the command channel is not ready until the last pixel of a run is taken
// arst_n clears the sequencer to idle; datapath registers are not reset
module rgb_linear_gradient_fill #(
	parameter int PIXELS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	rlgf_cmd_if.sink    cmd,
	rlgf_pix_if.source  pix
);

	localparam logic [rlgf_pkg::POS_W-1:0] MAX_POS = rlgf_pkg::POS_W'(PIXELS - 1);

	localparam logic [1:0] S_IDLE     = 2'd0;
	localparam logic [1:0] S_DIV_GO   = 2'd1;
	localparam logic [1:0] S_DIV_WAIT = 2'd2;
	localparam logic [1:0] S_EMIT     = 2'd3;

	logic [1:0] state_q;
	logic [rlgf_pkg::CHAN_W-1:0] chan_q;

	logic [rlgf_pkg::POS_W-1:0]  pos_q;
	logic [rlgf_pkg::POS_W-1:0]  hi_q;
	logic [rlgf_pkg::SPAN_W-1:0] span_q;
	logic [rlgf_pkg::COL_W-1:0]  lo_col_q [rlgf_pkg::NUM_CHAN];
	logic [rlgf_pkg::COL_W-1:0]  hi_col_q [rlgf_pkg::NUM_CHAN];
	logic [rlgf_pkg::ACC_W-1:0]  acc_q    [rlgf_pkg::NUM_CHAN];
	logic [rlgf_pkg::ACC_W-1:0]  step_q   [rlgf_pkg::NUM_CHAN];

	logic [rlgf_pkg::POS_W-1:0]  sp_c, ep_c, lo_pos_c, hi_pos_c;
	logic                        swap_c;
	logic [rlgf_pkg::COL_W-1:0]  s_col_c [rlgf_pkg::NUM_CHAN];
	logic [rlgf_pkg::COL_W-1:0]  e_col_c [rlgf_pkg::NUM_CHAN];

	logic [rlgf_pkg::COL_W-1:0]  col_a, col_b, diff_mag;
	logic                        diff_neg;

	logic                        cmd_fire;
	logic                        pix_fire;
	logic                        div_start;
	rlgf_pkg::div_req_t          div_req;
	rlgf_pkg::div_rsp_t          div_rsp;

	function automatic logic [rlgf_pkg::POS_W-1:0] clamp_pos(
		input logic [rlgf_pkg::POS_W-1:0] p
	);
		return (p > MAX_POS) ? MAX_POS : p;
	endfunction

	always_comb begin
		sp_c       = clamp_pos(cmd.start_pos);
		ep_c       = clamp_pos(cmd.end_pos);
		swap_c     = ep_c < sp_c;
		lo_pos_c   = swap_c ? ep_c : sp_c;
		hi_pos_c   = swap_c ? sp_c : ep_c;
		s_col_c[0] = cmd.start_red;
		s_col_c[1] = cmd.start_green;
		s_col_c[2] = cmd.start_blue;
		e_col_c[0] = cmd.end_red;
		e_col_c[1] = cmd.end_green;
		e_col_c[2] = cmd.end_blue;
	end

	// operands for the channel now on the divider
	always_comb begin
		col_a    = lo_col_q[chan_q];
		col_b    = hi_col_q[chan_q];
		diff_neg = col_b < col_a;
		diff_mag = diff_neg ? (col_a - col_b) : (col_b - col_a);
		div_req.mag     = {diff_mag, rlgf_pkg::FRAC_SH'(0)};
		div_req.divisor = span_q;
		div_req.neg     = diff_neg;
	end

	assign cmd_fire  = cmd.valid && cmd.ready;
	assign pix_fire  = pix.valid && pix.ready;
	assign div_start = (state_q == S_DIV_GO);

	rlgf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chan_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						chan_q  <= '0;
						state_q <= S_DIV_GO;
					end
				end
				S_DIV_GO: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_rsp.done) begin
						if (chan_q == rlgf_pkg::CHAN_W'(rlgf_pkg::NUM_CHAN - 1)) begin
							state_q <= S_EMIT;
						end else begin
							chan_q  <= chan_q + 1'b1;
							state_q <= S_DIV_GO;
						end
					end
				end
				S_EMIT: begin
					if (pix_fire && pix.run_last) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			pos_q  <= lo_pos_c;
			hi_q   <= hi_pos_c;
			span_q <= (hi_pos_c == lo_pos_c) ? rlgf_pkg::SPAN_W'(1) : (hi_pos_c - lo_pos_c);
			for (int c = 0; c < rlgf_pkg::NUM_CHAN; c++) begin
				lo_col_q[c] <= swap_c ? e_col_c[c] : s_col_c[c];
				hi_col_q[c] <= swap_c ? s_col_c[c] : e_col_c[c];
				acc_q[c]    <= {(swap_c ? e_col_c[c] : s_col_c[c]), 8'h00};
			end
		end else if (pix_fire) begin
			pos_q <= pos_q + 1'b1;
			for (int c = 0; c < rlgf_pkg::NUM_CHAN; c++) begin
				acc_q[c] <= acc_q[c] + step_q[c];
			end
		end
		// the step is the quotient doubled, modulo 2^16
		if (state_q == S_DIV_WAIT && div_rsp.done) begin
			step_q[chan_q] <= {div_rsp.quot[rlgf_pkg::ACC_W-2:0], 1'b0};
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign pix.valid       = (state_q == S_EMIT);
	assign pix.pixel_index = pos_q;
	assign pix.pixel_red   = acc_q[0][rlgf_pkg::ACC_W-1 -: rlgf_pkg::COL_W];
	assign pix.pixel_green = acc_q[1][rlgf_pkg::ACC_W-1 -: rlgf_pkg::COL_W];
	assign pix.pixel_blue  = acc_q[2][rlgf_pkg::ACC_W-1 -: rlgf_pkg::COL_W];
	assign pix.run_last    = (pos_q == hi_q);

endmodule

// ===== rtl/rlgf_div.sv =====
// iterative restoring divider, one quotient bit per cycle, signed result
module rlgf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  rlgf_pkg::div_req_t req,
	output rlgf_pkg::div_rsp_t rsp
);

	logic [rlgf_pkg::DIV_W-1:0]  work_q;
	logic [rlgf_pkg::SPAN_W-1:0] rem_q;
	logic [rlgf_pkg::SPAN_W-1:0] divisor_q;
	logic                        neg_q;
	logic [rlgf_pkg::CNT_W-1:0]  cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [rlgf_pkg::SPAN_W:0]   trial;
	logic                        ge;
	logic [rlgf_pkg::SPAN_W:0]   rem_n;
	logic [rlgf_pkg::ACC_W-1:0]  mag_ext;

	always_comb begin
		trial = {rem_q, work_q[rlgf_pkg::DIV_W-1]};
		ge    = trial >= {1'b0, divisor_q};
		rem_n = ge ? (trial - {1'b0, divisor_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rlgf_pkg::CNT_W'(rlgf_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rlgf_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			work_q    <= req.mag;
			rem_q     <= '0;
			divisor_q <= req.divisor;
			neg_q     <= req.neg;
		end else if (busy_q) begin
			work_q <= {work_q[rlgf_pkg::DIV_W-2:0], ge};
			rem_q  <= rem_n[rlgf_pkg::SPAN_W-1:0];
		end
	end

	// remainder stays below the divisor, so its top bit is dropped safely
	assign mag_ext  = rlgf_pkg::ACC_W'(work_q);
	assign rsp.done = done_q;
	assign rsp.quot = neg_q ? (rlgf_pkg::ACC_W'(0) - mag_ext) : mag_ext;

endmodule
